/* rtl/pid_pkg.sv */
package pid_pkg;

  localparam int MAX_TRAINS      = 8;
  localparam int TRAIN_BITS      = 3;
  localparam int TRAIN_CNT_BITS  = 4;
  localparam int MIN_TRAINS      = 2;
  localparam int PAIR_BITS       = 5;
  localparam int RATIO_FRAC_BITS = 14;
  localparam int QUO_BITS        = RATIO_FRAC_BITS + 1;
  localparam int RATIO_BITS      = 16;
  localparam int OUT_FIELD_BITS  = PAIR_BITS + 2 * TRAIN_BITS + RATIO_BITS;
  localparam int OUT_W           = ((OUT_FIELD_BITS + 7) / 8) * 8;

  localparam logic [TRAIN_CNT_BITS-1:0] TRAIN_COUNT_RESET = TRAIN_CNT_BITS'(MAX_TRAINS);

endpackage

/* rtl/pid_ram.sv */
module pid_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr_a,
  input  logic [AW-1:0]    rd_addr_b,
  output logic [WIDTH-1:0] rd_data_a,
  output logic [WIDTH-1:0] rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_a_r;
  logic [WIDTH-1:0] rd_b_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a_r <= mem[rd_addr_a];
    rd_b_r <= mem[rd_addr_b];
  end

  assign rd_data_a = rd_a_r;
  assign rd_data_b = rd_b_r;

endmodule

/* rtl/pid_div.sv */
// Restoring fraction divider, one quotient bit per cycle.
// Expects num <= den. quo = floor(num * 2^RATIO_FRAC_BITS / den).
module pid_div #(
  parameter int W = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [W-1:0]                  num,
  input  logic [W-1:0]                  den,
  output logic                          done,
  output logic [pid_pkg::QUO_BITS-1:0]  quo
);

  localparam int QB = pid_pkg::QUO_BITS;
  localparam int CW = $clog2(QB);
  localparam logic [CW-1:0] K_LAST = CW'(QB - 1);

  logic          run_r, run_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  den_r, den_nxt;
  logic [QB-1:0] q_r, q_nxt;

  logic [W:0]    trial;
  logic [W+1:0]  diff;
  logic          ge;

  always_comb begin
    // first step compares the numerator as is, later steps the doubled remainder
    trial = (k_r == '0) ? {1'b0, rem_r} : {rem_r, 1'b0};
    diff  = {1'b0, trial} - {2'b00, den_r};
    ge    = ~diff[W+1];

    run_nxt  = run_r;
    done_nxt = 1'b0;
    k_nxt    = k_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    q_nxt    = q_r;

    if (start) begin
      run_nxt = 1'b1;
      k_nxt   = '0;
      rem_nxt = num;
      den_nxt = den;
    end else if (run_r) begin
      rem_nxt = ge ? diff[W-1:0] : trial[W-1:0];
      q_nxt   = {q_r[QB-2:0], ge};
      k_nxt   = CW'(k_r + 1'b1);
      if (k_r == K_LAST) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      k_r    <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      k_r    <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

/* rtl/pairwise_isi_ratio.sv */
// Channel  Direction  Handshake            Payload
// in_      slave      in_tvalid/in_tready  tdata: interval
// out_     master     out_tvalid/tready    tdata: pair_index, first_train, second_train,
//                                          ratio; tlast: last_of_sample
// cfg_     write      cfg_wr_en            cfg_wr_data: train_count
//
// One interval is taken per cycle while a sample loads.
// Each pair then goes through one RAM read, one compare/subtract and the bit-per-cycle
// divider (15 quotient bits plus done). No new interval is taken until the last pair
// of the sample has been emitted.
// Reset (rst_n low, synchronous) sets train_count to 8 and empties the sample;
// the interval RAM is not cleared. A stalled result waits in the output register;
// the sequencer holds the next finished pair until it is taken.
module pairwise_isi_ratio #(
  parameter int INTERVAL_BITS = 32,
  localparam int IN_W = ((INTERVAL_BITS + 7) / 8) * 8
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [IN_W-1:0]                       in_tdata,   // interval
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // pair_index, first_train, second_train, ratio, zero fill
  output logic [pid_pkg::OUT_W-1:0]             out_tdata,
  output logic                                  out_tlast,  // last_of_sample
  input  logic                                  cfg_wr_en,
  input  logic [pid_pkg::TRAIN_CNT_BITS-1:0]    cfg_wr_data // train_count
);

  localparam int TB = pid_pkg::TRAIN_BITS;
  localparam int CB = pid_pkg::TRAIN_CNT_BITS;
  localparam int PB = pid_pkg::PAIR_BITS;
  localparam int RB = pid_pkg::RATIO_BITS;
  localparam int QB = pid_pkg::QUO_BITS;
  localparam int OW = pid_pkg::OUT_W;
  localparam int FB = pid_pkg::OUT_FIELD_BITS;

  typedef enum logic [4:0] {
    S_LOAD = 5'b00001,
    S_RD   = 5'b00010,
    S_PREP = 5'b00100,
    S_DIV  = 5'b01000,
    S_HOLD = 5'b10000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CB-1:0]    train_count_r, train_count_nxt;
  logic [CB-1:0]    load_cnt_r, load_cnt_nxt;
  logic [TB-1:0]    i_r, i_nxt;
  logic [TB-1:0]    j_r, j_nxt;
  logic [PB-1:0]    pair_cnt_r, pair_cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             neg_r, neg_nxt;
  logic             zero_r, zero_nxt;
  logic [OW-1:0]    out_data_r, out_data_nxt;
  logic             out_last_r, out_last_nxt;

  logic [CB-1:0]              n_eff;
  logic [CB-1:0]              load_cnt_inc;
  logic                       in_acc;
  logic                       last_pair;
  logic                       out_free;
  logic                       emit;
  logic [INTERVAL_BITS-1:0]   rd_a, rd_b;
  logic                       a_lt_b;
  logic [INTERVAL_BITS-1:0]   div_num, div_den;
  logic                       div_start, div_done;
  logic [QB-1:0]              div_quo;
  logic [RB-1:0]              mag, ratio;

  pid_ram #(
    .WIDTH (INTERVAL_BITS),
    .DEPTH (pid_pkg::MAX_TRAINS)
  ) u_store (
    .clk       (clk),
    .wr_en     (in_acc),
    .wr_addr   (load_cnt_r[TB-1:0]),
    .wr_data   (in_tdata[INTERVAL_BITS-1:0]),
    .rd_addr_a (i_r),
    .rd_addr_b (j_r),
    .rd_data_a (rd_a),
    .rd_data_b (rd_b)
  );

  pid_div #(
    .W (INTERVAL_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    if (train_count_r < CB'(pid_pkg::MIN_TRAINS)) begin
      n_eff = CB'(pid_pkg::MIN_TRAINS);
    end else if (train_count_r > CB'(pid_pkg::MAX_TRAINS)) begin
      n_eff = CB'(pid_pkg::MAX_TRAINS);
    end else begin
      n_eff = train_count_r;
    end
  end

  assign in_tready    = (state_r == S_LOAD);
  assign in_acc       = in_tvalid && in_tready;
  assign load_cnt_inc = CB'(load_cnt_r + 1'b1);
  assign last_pair    = ({1'b0, i_r} == CB'(n_eff - 2'd2)) &&
                        ({1'b0, j_r} == CB'(n_eff - 1'b1));
  assign out_free     = !out_valid_r || out_tready;

  // a < b gives -(b-a)/b, otherwise (a-b)/a; both zero forces the ratio to 0
  assign a_lt_b    = rd_a < rd_b;
  assign div_num   = a_lt_b ? (rd_b - rd_a) : (rd_a - rd_b);
  assign div_den   = a_lt_b ? rd_b : rd_a;
  assign div_start = (state_r == S_PREP);

  assign mag   = RB'(div_quo);
  assign ratio = zero_r ? '0 : (neg_r ? RB'(-mag) : mag);
  assign emit  = ((state_r == S_DIV && div_done) || state_r == S_HOLD) && out_free;

  always_comb begin
    state_nxt       = state_r;
    train_count_nxt = train_count_r;
    load_cnt_nxt    = load_cnt_r;
    i_nxt           = i_r;
    j_nxt           = j_r;
    pair_cnt_nxt    = pair_cnt_r;
    neg_nxt         = neg_r;
    zero_nxt        = zero_r;
    out_valid_nxt   = out_valid_r;
    out_data_nxt    = out_data_r;
    out_last_nxt    = out_last_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_LOAD: begin
        if (in_acc) begin
          if (load_cnt_inc == n_eff) begin
            load_cnt_nxt = '0;
            i_nxt        = '0;
            j_nxt        = TB'(1);
            pair_cnt_nxt = '0;
            state_nxt    = S_RD;
          end else begin
            load_cnt_nxt = load_cnt_inc;
          end
        end
      end
      S_RD: begin
        state_nxt = S_PREP;
      end
      S_PREP: begin
        neg_nxt   = a_lt_b;
        zero_nxt  = !a_lt_b && (rd_a == '0);
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done && !out_free) begin
          state_nxt = S_HOLD;
        end
      end
      S_HOLD: begin
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase

    if (emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = OW'({ratio, j_r, i_r, pair_cnt_r});
      out_last_nxt  = last_pair;
      if (last_pair) begin
        pair_cnt_nxt = '0;
        state_nxt    = S_LOAD;
      end else begin
        pair_cnt_nxt = PB'(pair_cnt_r + 1'b1);
        if ({1'b0, j_r} == CB'(n_eff - 1'b1)) begin
          i_nxt = TB'(i_r + 1'b1);
          j_nxt = TB'(i_r + 2'd2);
        end else begin
          j_nxt = TB'(j_r + 1'b1);
        end
        state_nxt = S_RD;
      end
    end

    if (cfg_wr_en) begin
      train_count_nxt = cfg_wr_data;
      load_cnt_nxt    = '0;
      pair_cnt_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_LOAD;
      train_count_r <= pid_pkg::TRAIN_COUNT_RESET;
      load_cnt_r    <= '0;
      i_r           <= '0;
      j_r           <= '0;
      pair_cnt_r    <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      train_count_r <= train_count_nxt;
      load_cnt_r    <= load_cnt_nxt;
      i_r           <= i_nxt;
      j_r           <= j_nxt;
      pair_cnt_r    <= pair_cnt_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r      <= neg_nxt;
    zero_r     <= zero_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_data_r[OW-1:FB] & '0, out_data_r[FB-1:0]};
  assign out_tlast  = out_last_r;

endmodule

/* tb/sv/pairwise_isi_ratio_tb.sv */
module pairwise_isi_ratio_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RAND_ITEMS   = 150;
  localparam int QUIET_ITEMS  = 40;
  localparam int DRAIN_CYCLES = 24;
  localparam int HOLD_CYCLES  = 700;
  localparam int END_CYCLES   = 60;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic [pid_pkg::PAIR_BITS-1:0]  pair_index;
    logic [pid_pkg::TRAIN_BITS-1:0] first_train;
    logic [pid_pkg::TRAIN_BITS-1:0] second_train;
    logic [pid_pkg::RATIO_BITS-1:0] ratio;
    logic                           last_of_sample;
  } pair_t;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;
  typedef enum int {IV_RANDOM, IV_SMALL, IV_CLUSTER, IV_EDGE} iv_style_t;

  typedef struct {
    row_kind_t                      kind;
    logic [31:0]                    val;
    bit                             chk;
    logic [pid_pkg::RATIO_BITS-1:0] ratio;
  } row_t;

  logic                               clk;
  logic                               rst_n;
  logic                               in_tvalid;
  logic                               in_tready;
  logic [31:0]                        in_tdata;
  logic                               out_tvalid;
  logic                               out_tready;
  logic [pid_pkg::OUT_W-1:0]          out_tdata;
  logic                               out_tlast;
  logic                               cfg_wr_en;
  logic [pid_pkg::TRAIN_CNT_BITS-1:0] cfg_wr_data;

  // predictor state
  logic [31:0]                        train_ivals [pid_pkg::MAX_TRAINS];
  int unsigned                        ivals_loaded;
  logic [pid_pkg::TRAIN_CNT_BITS-1:0] train_count;
  pair_t                              pending_pairs [$];

  pair_t want;
  pair_t got;
  int    errors;
  int    items_sent;
  int    pairs_checked;
  int    cfg_writes;
  int    cycles;
  bit    quiet;
  bit    tx_idle_on;
  bit    rx_idle_on;
  bit    hold_req;

  // short samples with ratios that can be read off directly, then a dropped
  // partial sample and a full eight-train sample
  row_t dir_rows [30] = '{
    '{ROW_CFG,  32'd2,          1'b0, 16'sd0},
    '{ROW_ITEM, 32'd0,          1'b0, 16'sd0},
    '{ROW_ITEM, 32'd0,          1'b1, 16'sd0},       // both zero
    '{ROW_ITEM, 32'd0,          1'b0, 16'sd0},
    '{ROW_ITEM, 32'd5,          1'b1, -16'sd16384},  // first zero
    '{ROW_ITEM, 32'd5,          1'b0, 16'sd0},
    '{ROW_ITEM, 32'd0,          1'b1, 16'sd16384},
    '{ROW_ITEM, 32'hFFFF_FFFF,  1'b0, 16'sd0},
    '{ROW_ITEM, 32'hFFFF_FFFF,  1'b1, 16'sd0},
    '{ROW_ITEM, 32'd1,          1'b0, 16'sd0},
    '{ROW_ITEM, 32'hFFFF_FFFF,  1'b1, -16'sd16383},
    '{ROW_ITEM, 32'hFFFF_FFFF,  1'b0, 16'sd0},
    '{ROW_ITEM, 32'd1,          1'b1, 16'sd16383},
    '{ROW_ITEM, 32'd1,          1'b0, 16'sd0},
    '{ROW_ITEM, 32'd2,          1'b1, -16'sd8192},
    '{ROW_CFG,  32'd0,          1'b0, 16'sd0},       // below range, acts as 2
    '{ROW_ITEM, 32'd3,          1'b0, 16'sd0},
    '{ROW_ITEM, 32'd4,          1'b1, -16'sd4096},
    '{ROW_CFG,  32'd3,          1'b0, 16'sd0},
    '{ROW_ITEM, 32'd9,          1'b0, 16'sd0},
    '{ROW_ITEM, 32'd10,         1'b0, 16'sd0},
    '{ROW_CFG,  32'd15,         1'b0, 16'sd0},       // drops partial, acts as 8
    '{ROW_ITEM, 32'd100,        1'b0, 16'sd0},
    '{ROW_ITEM, 32'd0,          1'b0, 16'sd0},
    '{ROW_ITEM, 32'd50,         1'b0, 16'sd0},
    '{ROW_ITEM, 32'd200,        1'b0, 16'sd0},
    '{ROW_ITEM, 32'h8000_0000,  1'b0, 16'sd0},
    '{ROW_ITEM, 32'd7,          1'b0, 16'sd0},
    '{ROW_ITEM, 32'd7,          1'b0, 16'sd0},
    '{ROW_ITEM, 32'hDEAD_BEEF,  1'b0, 16'sd0}
  };

  pairwise_isi_ratio u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int active_trains();
    int n;
    n = int'(train_count);
    if (n < pid_pkg::MIN_TRAINS) n = pid_pkg::MIN_TRAINS;
    if (n > pid_pkg::MAX_TRAINS) n = pid_pkg::MAX_TRAINS;
    return n;
  endfunction

  // truncated toward zero: a/b-1 when a<b, else 1-b/a
  function automatic logic [pid_pkg::RATIO_BITS-1:0] isi_ratio(logic [31:0] a,
                                                               logic [31:0] b);
    logic [63:0] q;
    if (a < b) begin
      q = (64'(b - a) << pid_pkg::RATIO_FRAC_BITS) / 64'(b);
      return pid_pkg::RATIO_BITS'(-q);
    end
    if (a == 0) return '0;
    q = (64'(a - b) << pid_pkg::RATIO_FRAC_BITS) / 64'(a);
    return pid_pkg::RATIO_BITS'(q);
  endfunction

  function automatic void load_interval(logic [31:0] v);
    int n;
    int pidx;
    pair_t p;
    n = active_trains();
    if (ivals_loaded >= n) ivals_loaded = 0;
    train_ivals[ivals_loaded] = v;
    ivals_loaded++;
    if (ivals_loaded < n) return;
    pidx = 0;
    for (int i = 0; i < n - 1; i++) begin
      for (int j = i + 1; j < n; j++) begin
        p.pair_index     = pid_pkg::PAIR_BITS'(pidx);
        p.first_train    = pid_pkg::TRAIN_BITS'(i);
        p.second_train   = pid_pkg::TRAIN_BITS'(j);
        p.ratio          = isi_ratio(train_ivals[i], train_ivals[j]);
        p.last_of_sample = (pidx + 1 == n * (n - 1) / 2);
        pending_pairs.push_back(p);
        pidx++;
      end
    end
    ivals_loaded = 0;
  endfunction

  function automatic logic [31:0] pick_interval(iv_style_t style, logic [31:0] base);
    case (style)
      IV_SMALL:   return 32'($urandom_range(0, 3));
      IV_CLUSTER: return base + 32'($urandom_range(0, 2));
      IV_EDGE: begin
        case ($urandom_range(0, 4))
          0:       return 32'd0;
          1:       return 32'd1;
          2:       return 32'hFFFF_FFFF;
          3:       return 32'hFFFF_FFFE;
          default: return 32'h8000_0000;
        endcase
      end
      default:    return $urandom();
    endcase
  endfunction

  // entered and left just after a rising edge
  task automatic send_interval(logic [31:0] v);
    if (!quiet && tx_idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    do @(posedge clk); while (!in_tready);
    load_interval(v);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_pairs.size() != 0);
  endtask

  task automatic write_train_count(logic [pid_pkg::TRAIN_CNT_BITS-1:0] v);
    wait_drained();
    // loading an item yields no result, so give the block time to settle
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en    <= 1'b0;
    train_count  = v;
    ivals_loaded = 0;
    cfg_writes++;
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin : rx_side
    int held;
    out_tready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        held = 0;
        while (held < HOLD_CYCLES) begin
          @(posedge clk);
          held++;
        end
        hold_req = 1'b0;
      end else if (!quiet && rx_idle_on && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got.pair_index     = out_tdata[4:0];
      got.first_train    = out_tdata[7:5];
      got.second_train   = out_tdata[10:8];
      got.ratio          = out_tdata[26:11];
      got.last_of_sample = out_tlast;
      if (pending_pairs.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected result: pair %0d (%0d,%0d) ratio %0d last %0b",
                   got.pair_index, got.first_train, got.second_train,
                   $signed(got.ratio), got.last_of_sample);
      end else begin
        want = pending_pairs.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display({"mismatch: expected pair %0d (%0d,%0d) ratio %0d last %0b, ",
                      "got pair %0d (%0d,%0d) ratio %0d last %0b"},
                     want.pair_index, want.first_train, want.second_train,
                     $signed(want.ratio), want.last_of_sample,
                     got.pair_index, got.first_train, got.second_train,
                     $signed(got.ratio), got.last_of_sample);
        end
        pairs_checked++;
      end
    end
  end

  initial begin : watchdog
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycles,
             pending_pairs.size());
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    int rand_items;
    int phase;
    int n;
    int partial;
    iv_style_t style;
    logic [31:0] base;
    errors       = 0;
    items_sent   = 0;
    pairs_checked = 0;
    cfg_writes   = 0;
    quiet        = 1'b0;
    tx_idle_on   = 1'b1;
    rx_idle_on   = 1'b1;
    hold_req     = 1'b0;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    train_count  = pid_pkg::TRAIN_COUNT_RESET;
    ivals_loaded = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_CFG) begin
        write_train_count(pid_pkg::TRAIN_CNT_BITS'(dir_rows[r].val));
      end else begin
        send_interval(dir_rows[r].val);
        if (dir_rows[r].chk) pending_pairs[$].ratio = dir_rows[r].ratio;
      end
    end

    rand_items = 0;
    phase      = 0;
    while (rand_items < RAND_ITEMS) begin
      // the hold-off phase runs eight trains so the block backs up into its input
      if (phase == 3) write_train_count(pid_pkg::TRAIN_CNT_BITS'(pid_pkg::MAX_TRAINS));
      else write_train_count(pid_pkg::TRAIN_CNT_BITS'($urandom_range(0, 15)));
      n          = active_trains();
      tx_idle_on = ($urandom_range(0, 2) != 0);
      rx_idle_on = ($urandom_range(0, 2) != 0);
      if (phase == 3) hold_req = 1'b1;
      repeat ($urandom_range(1, 3)) begin
        if (phase == 5) wait_drained();
        style = iv_style_t'($urandom_range(0, 5) > 3 ? $urandom_range(1, 3) : 0);
        base  = $urandom();
        for (int k = 0; k < n; k++) begin
          send_interval(pick_interval(style, base));
          rand_items++;
        end
        quiet = (rand_items >= RAND_ITEMS - QUIET_ITEMS);
      end
      // broken sample, dropped by the next register write
      if (!quiet && $urandom_range(0, 3) == 0) begin
        partial = $urandom_range(1, n - 1);
        for (int k = 0; k < partial; k++) send_interval($urandom());
      end
      phase++;
    end

    wait_drained();
    repeat (END_CYCLES) @(posedge clk);
    $display("sent %0d intervals over %0d train-count writes, checked %0d pair ratios",
             items_sent, cfg_writes, pairs_checked);
    $display("%0d mismatches, %0d results never arrived", errors, pending_pairs.size());
    if (errors == 0 && pending_pairs.size() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
